// File: rtl/tlf_pkg.sv
// Shared types and constants of the text line folder.
package tlf_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COL_W      = 6;
  localparam int unsigned CFG_W      = 6;
  localparam int unsigned COL_SAT    = 63;
  localparam int unsigned FOLD_RESET = 10;

  localparam logic [BYTE_W-1:0] CH_NL    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
  } out_word_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_NL
  } state_e;

endpackage

// File: rtl/tlf_cell.sv
// One byte cell of the line store row; loads a new byte or takes its right neighbor's byte.
module tlf_cell (
  input  logic                           clk_i,
  input  tlf_pkg::cell_ctrl_t            ctrl_i,
  input  logic [tlf_pkg::BYTE_W-1:0]     right_i,
  input  logic [tlf_pkg::BYTE_W-1:0]     load_i,
  output logic [tlf_pkg::BYTE_W-1:0]     byte_o
);

  logic [tlf_pkg::BYTE_W-1:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.load) begin
      byte_d = load_i;
    end else if (ctrl_i.shift) begin
      byte_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

// File: rtl/text_line_folder_top.sv
// Text line folder: a plain byte that fits on the line is stored and yields no word, so
// ordinary text streams at one byte per cycle. A newline, an end-of-input item after stored
// bytes or a byte that forces a fold is accepted and then holds off input while the held
// bytes (on a split at a blank, those before it) leave the cell row one per cycle, while the
// sink accepts them, through the output register, followed by a newline where one is due:
// such an item emits at most MAX_COLUMN + 1 words.
module text_line_folder_top #(
  parameter int unsigned MAX_COLUMN = 32,
  parameter int unsigned TAB_STOP   = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tlf_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tlf_pkg::in_word_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tlf_pkg::out_word_t            out_data_o
);

  localparam int unsigned FW = $clog2(MAX_COLUMN + 1);
  localparam int unsigned PW = $clog2(TAB_STOP + 1);
  localparam int unsigned CW = tlf_pkg::COL_W;
  localparam int unsigned BW = tlf_pkg::BYTE_W;

  tlf_pkg::state_e state_q, state_d;

  logic [tlf_pkg::CFG_W-1:0] fold_q;
  logic [FW-1:0] fill_q, fill_d;
  logic [CW-1:0] col_q, col_d;
  logic [PW-1:0] phase_q, phase_d;
  logic [FW-1:0] lblank_q, lblank_d;
  logic [FW-1:0] tlen_q, tlen_d;
  logic [PW-1:0] tphase_q, tphase_d;
  logic [FW-1:0] cnt_q, cnt_d;
  logic [BW-1:0] pend_q, pend_d;
  logic          pend_v_q, pend_v_d;
  logic          drop_q, drop_d;
  logic          nl_q, nl_d;

  logic                out_valid_q, out_valid_d;
  tlf_pkg::out_word_t  out_q, prod_word;
  logic                produce, adv;

  logic          app_en, shift_en;
  logic [BW-1:0] app_byte;
  logic [PW-1:0] width_w, phase_inc, tphase_inc;
  logic [CW:0]   col_sum, n_lim, fold_ext;
  logic          is_fold, found;
  logic [FW-1:0] fold_cnt;
  logic          app_blank;

  logic [BW-1:0]       cell_byte [MAX_COLUMN];
  tlf_pkg::cell_ctrl_t cell_ctrl [MAX_COLUMN];

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == tlf_pkg::ST_IDLE);

  // A fold column of zero acts as one; values past the row length act as the row length.
  assign fold_ext = {1'b0, fold_q};
  always_comb begin
    if (fold_q == '0) begin
      n_lim = (CW+1)'(1);
    end else if (fold_ext > (CW+1)'(MAX_COLUMN)) begin
      n_lim = (CW+1)'(MAX_COLUMN);
    end else begin
      n_lim = fold_ext;
    end
  end

  assign app_byte   = (state_q == tlf_pkg::ST_NL) ? pend_q : in_data_i.in_byte;
  assign app_blank  = (app_byte == tlf_pkg::CH_SPACE) || (app_byte == tlf_pkg::CH_TAB);
  assign width_w    = (app_byte == tlf_pkg::CH_TAB) ? PW'(TAB_STOP) - phase_q : PW'(1);
  assign phase_inc  = (phase_q == PW'(TAB_STOP - 1)) ? '0 : phase_q + PW'(1);
  assign tphase_inc = (tphase_q == PW'(TAB_STOP - 1)) ? '0 : tphase_q + PW'(1);
  assign col_sum    = {1'b0, col_q} + (CW+1)'(width_w);

  assign is_fold  = (col_sum > n_lim) || (fill_q >= FW'(MAX_COLUMN));
  // The last blank position is tracked on each store, so no search of the row is needed.
  assign found    = (lblank_q != '0) && (fill_q < FW'(MAX_COLUMN));
  assign fold_cnt = found ? lblank_q - FW'(1) : fill_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tlf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.end_of_input) begin
            state_d = (fill_q != '0) ? tlf_pkg::ST_EMIT : tlf_pkg::ST_IDLE;
          end else if (in_data_i.in_byte == tlf_pkg::CH_NL) begin
            state_d = (fill_q != '0) ? tlf_pkg::ST_EMIT : tlf_pkg::ST_NL;
          end else if (is_fold) begin
            state_d = (fold_cnt != '0) ? tlf_pkg::ST_EMIT : tlf_pkg::ST_NL;
          end
        end
      end
      tlf_pkg::ST_EMIT: begin
        if (adv && cnt_q == FW'(1)) begin
          state_d = nl_q ? tlf_pkg::ST_NL : tlf_pkg::ST_IDLE;
        end
      end
      tlf_pkg::ST_NL: begin
        if (adv) begin
          state_d = tlf_pkg::ST_IDLE;
        end
      end
      default: state_d = tlf_pkg::ST_IDLE;
    endcase
  end

  // Datapath and sequencer outputs.
  always_comb begin
    fill_d    = fill_q;
    col_d     = col_q;
    phase_d   = phase_q;
    lblank_d  = lblank_q;
    tlen_d    = tlen_q;
    tphase_d  = tphase_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    drop_d    = drop_q;
    nl_d      = nl_q;
    produce   = 1'b0;
    prod_word = '0;
    shift_en  = 1'b0;
    app_en    = 1'b0;
    unique case (state_q)
      tlf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.end_of_input || in_data_i.in_byte == tlf_pkg::CH_NL ||
              is_fold) begin
            nl_d     = !in_data_i.end_of_input;
            pend_d   = in_data_i.in_byte;
            pend_v_d = !in_data_i.end_of_input &&
                       (in_data_i.in_byte != tlf_pkg::CH_NL);
            lblank_d = '0;
            if (pend_v_d && found) begin
              // Split at the last blank; the remainder after it holds no blank.
              cnt_d   = fold_cnt;
              drop_d  = 1'b1;
              fill_d  = tlen_q;
              col_d   = CW'(tlen_q);
              phase_d = tphase_q;
            end else begin
              cnt_d    = fill_q;
              drop_d   = 1'b0;
              fill_d   = '0;
              col_d    = '0;
              phase_d  = '0;
              tlen_d   = '0;
              tphase_d = '0;
            end
          end else begin
            app_en = 1'b1;
          end
        end
      end
      tlf_pkg::ST_EMIT: begin
        if (adv) begin
          produce               = 1'b1;
          prod_word.out_byte    = cell_byte[0];
          prod_word.last_of_run = (cnt_q == FW'(1)) && !nl_q;
          shift_en              = 1'b1;
          cnt_d                 = cnt_q - FW'(1);
        end
      end
      tlf_pkg::ST_NL: begin
        if (adv) begin
          produce               = 1'b1;
          prod_word.out_byte    = tlf_pkg::CH_NL;
          prod_word.last_of_run = 1'b1;
          // The newline goes out in the same cycle that the split blank leaves the row.
          shift_en              = drop_q;
          app_en                = pend_v_q;
          pend_v_d              = 1'b0;
        end
      end
      default: ;
    endcase

    if (app_en) begin
      fill_d  = fill_q + FW'(1);
      col_d   = (col_sum > (CW+1)'(tlf_pkg::COL_SAT)) ? CW'(tlf_pkg::COL_SAT)
                                                       : col_sum[CW-1:0];
      phase_d = (app_byte == tlf_pkg::CH_TAB) ? '0 : phase_inc;
      if (app_blank) begin
        lblank_d = fill_q + FW'(1);
        tlen_d   = '0;
        tphase_d = '0;
      end else begin
        tlen_d   = tlen_q + FW'(1);
        tphase_d = tphase_inc;
      end
    end
  end

  assign out_valid_d = produce ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  for (genvar j = 0; j < MAX_COLUMN; j++) begin : g_cell
    logic [BW-1:0] right_w;
    assign cell_ctrl[j].shift = shift_en;
    assign cell_ctrl[j].load  = app_en && (fill_q == FW'(j));
    if (j == MAX_COLUMN - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = cell_byte[j+1];
    end
    tlf_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[j]),
      .right_i (right_w),
      .load_i  (app_byte),
      .byte_o  (cell_byte[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlf_pkg::ST_IDLE;
      fold_q      <= tlf_pkg::CFG_W'(tlf_pkg::FOLD_RESET);
      fill_q      <= '0;
      col_q       <= '0;
      phase_q     <= '0;
      lblank_q    <= '0;
      tlen_q      <= '0;
      tphase_q    <= '0;
      cnt_q       <= '0;
      pend_v_q    <= 1'b0;
      drop_q      <= 1'b0;
      nl_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        fold_q <= cfg_wdata_i;
      end
      fill_q      <= fill_d;
      col_q       <= col_d;
      phase_q     <= phase_d;
      lblank_q    <= lblank_d;
      tlen_q      <= tlen_d;
      tphase_q    <= tphase_d;
      cnt_q       <= cnt_d;
      pend_v_q    <= pend_v_d;
      drop_q      <= drop_d;
      nl_q        <= nl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (produce) begin
      out_q <= prod_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/tlf_checker.sv
// Port-level checks of the text line folder and the bind that attaches them.
module tlf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input tlf_pkg::in_word_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input tlf_pkg::out_word_t out_data_o
);

  a_out_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped before it was taken");

  a_out_hold_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("stalled output word changed");

  // While more words of the same run are due, no new input word may be taken.
  a_busy_mid_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_run |-> !in_ready_o)
    else $error("input ready in the middle of an output run");

  // Newlines are never stored, so every newline ends its run.
  a_nl_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.out_byte == tlf_pkg::CH_NL) |-> out_data_o.last_of_run)
    else $error("newline word not marked as last of its run");

endmodule

bind text_line_folder_top tlf_checker u_tlf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
